// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_pkg
// shared widths, constants and configuration type of the thrust curve unit
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int unsigned HOVER_ACCEL_DEF = 9797;
    localparam int unsigned ACC_W           = 15;
    localparam int unsigned MASS_W          = 16;
    localparam int unsigned THR_W           = 16;
    localparam int unsigned FORCE_W         = 20;
    localparam int unsigned FMAX_W          = 21;
    localparam int unsigned QV_W            = 17;
    localparam int unsigned FRAC_W          = 16;
    localparam int unsigned SIDE_W          = 1 + FMAX_W;

    localparam logic [QV_W-1:0]    ONE_Q16  = 17'd65536;
    localparam logic [QV_W-1:0]    HALF_Q16 = 17'd32768;
    localparam logic [THR_W-1:0]   HT_LOW   = 16'd3277;
    localparam logic [THR_W-1:0]   HT_HIGH  = 16'd62259;
    localparam logic [FMAX_W-1:0]  MAX_GAP  = 21'd1000;
    localparam logic [FORCE_W-1:0] OUT_MAX  = 20'hFFFFF;

    typedef struct packed {
        logic [FORCE_W-1:0] fmin;
        logic [FMAX_W-1:0]  fmax;
        logic [THR_W-1:0]   hov_thr;
        logic [QV_W-1:0]    expo;
        logic [THR_W-1:0]   dband;
        logic [FORCE_W-1:0] hov_force;
        logic [FORCE_W-1:0] down_auth;
        logic [FORCE_W-1:0] up_auth;
    } t_cfg;

endpackage

// ===== design/ttc_div.sv =====
// ----------------------------------------------------------------------------
// ttc_div
// pipelined rounding divider, one quotient bit per stage
// q = (diff * 65536 + den / 2) / den, with diff <= den
// ----------------------------------------------------------------------------
module ttc_div
    import ttc_pkg::*;
#(
    parameter int unsigned SIDE_BITS = SIDE_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [QV_W-1:0]      i_diff,
    input  logic [QV_W-1:0]      i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [QV_W-1:0]      o_quot,
    output logic [SIDE_BITS-1:0] o_side
);

    localparam int unsigned NUM_W = 2 * QV_W;

    logic [NUM_W-1:0]     n_num;
    logic                 r_v    [0:QV_W];
    logic [QV_W-1:0]      r_rem  [0:QV_W];
    logic [QV_W-1:0]      r_low  [0:QV_W];
    logic [QV_W-1:0]      r_den  [0:QV_W];
    logic [QV_W-1:0]      r_q    [0:QV_W];
    logic [SIDE_BITS-1:0] r_side [0:QV_W];

    assign n_num = {1'b0, i_diff, FRAC_W'(0)} + NUM_W'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= n_num[NUM_W-1:QV_W];
            r_low[0]  <= n_num[QV_W-1:0];
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QV_W; k++) begin : g_step
        logic [QV_W:0] w_trial;
        logic          w_ge;
        logic [QV_W:0] w_sub;

        assign w_trial = {r_rem[k-1], r_low[k-1][QV_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[k-1]};
        assign w_sub   = w_trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_sub[QV_W-1:0] : w_trial[QV_W-1:0];
                r_low[k]  <= {r_low[k-1][QV_W-2:0], 1'b0};
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= {r_q[k-1][QV_W-2:0], w_ge};
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[QV_W];
    assign o_quot  = r_q[QV_W];
    assign o_side  = r_side[QV_W];

endmodule

// ===== design/ttc_hover.sv =====
// ----------------------------------------------------------------------------
// ttc_hover
// hover force pipeline: mass times gravity, divide by 1000, select and clamp
// ----------------------------------------------------------------------------
module ttc_hover
    import ttc_pkg::*;
#(
    parameter int unsigned HOVER_ACCEL = HOVER_ACCEL_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [THR_W-1:0]  i_throttle,
    input  logic [MASS_W-1:0] i_mass,
    input  t_cfg              i_cfg,
    output logic              o_valid,
    output logic [THR_W-1:0]  o_throttle,
    output logic [FMAX_W-1:0] o_hf
);

    localparam int unsigned X_W   = MASS_W + ACC_W;
    localparam int unsigned Y_W   = X_W - 3;
    localparam int unsigned YH_W  = Y_W / 2;
    localparam int unsigned M_W   = 29;
    localparam int unsigned P_W   = YH_W + M_W;
    localparam int unsigned S_W   = Y_W + M_W + 1;
    localparam int unsigned SHIFT = 35;
    localparam logic [M_W-1:0] RECIP_125 = 29'd274877907;

    logic              r1_v, r2_v, r3_v;
    logic [THR_W-1:0]  r1_t, r2_t, r3_t;
    logic [X_W-1:0]    r1_x;
    logic [P_W-1:0]    r2_phi, r2_plo;
    logic [FMAX_W-1:0] r3_hf;
    logic [Y_W-1:0]    w_y;
    logic [S_W-1:0]    w_sum;
    logic [FMAX_W-1:0] w_q, w_sel;

    assign w_y   = r1_x[X_W-1:3];
    assign w_sum = {r2_phi, YH_W'(0)} + S_W'(r2_plo);
    assign w_q   = w_sum[SHIFT+FMAX_W-1:SHIFT];
    assign w_sel = (i_cfg.hov_force != '0) ? {1'b0, i_cfg.hov_force} : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        if (i_en) begin
            r1_t   <= i_throttle;
            r1_x   <= X_W'(i_mass) * X_W'(HOVER_ACCEL) + X_W'(500);
            r2_t   <= r1_t;
            r2_phi <= w_y[Y_W-1:YH_W] * RECIP_125;
            r2_plo <= w_y[YH_W-1:0] * RECIP_125;
            r3_t   <= r2_t;
            if (w_sel < {1'b0, i_cfg.fmin}) begin
                r3_hf <= {1'b0, i_cfg.fmin};
            end else if (w_sel > i_cfg.fmax) begin
                r3_hf <= i_cfg.fmax;
            end else begin
                r3_hf <= w_sel;
            end
        end
    end

    assign o_valid    = r3_v;
    assign o_throttle = r3_t;
    assign o_hf       = r3_hf;

endmodule

// ===== design/ttc_curve.sv =====
// ----------------------------------------------------------------------------
// ttc_curve
// cubic expo curve, authority scaling and force clamp, ending in the
// output register
// ----------------------------------------------------------------------------
module ttc_curve
    import ttc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [QV_W-1:0]    i_r,
    input  logic               i_pos,
    input  logic [FMAX_W-1:0]  i_hf,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic [FORCE_W-1:0] o_force
);

    localparam int unsigned P_W  = 2 * QV_W;
    localparam int unsigned PA_W = QV_W + FMAX_W;
    localparam int unsigned D_W  = PA_W + 1 - FRAC_W;
    localparam int unsigned F_W  = D_W + 1;

    logic               r_v [1:7];
    logic [QV_W-1:0]    r1_r, r2_r, r3_r;
    logic               r1_pos, r2_pos, r3_pos, r4_pos, r5_pos, r6_pos;
    logic [FMAX_W-1:0]  r1_hf, r2_hf, r3_hf, r4_hf, r5_hf, r6_hf;
    logic [FMAX_W-1:0]  r1_auth, r2_auth, r3_auth, r4_auth, r5_auth;
    logic [P_W-1:0]     r1_sq, r2_p, r4_p;
    logic [QV_W-1:0]    r3_w, r5_s;
    logic [PA_W-1:0]    r6_p;
    logic [FORCE_W-1:0] r7_force;

    logic [FMAX_W-1:0]  w_auth;
    logic [P_W-1:0]     w_sq_rnd, w_q_rnd, w_s_rnd;
    logic [QV_W:0]      w_w;
    logic [PA_W:0]      w_d_rnd;
    logic [D_W-1:0]     w_delta;
    logic [F_W-1:0]     w_force, w_clamp;

    always_comb begin
        if (i_pos) begin
            w_auth = (i_cfg.up_auth != '0) ? {1'b0, i_cfg.up_auth} : i_cfg.fmax - i_hf;
        end else begin
            w_auth = (i_cfg.down_auth != '0) ? {1'b0, i_cfg.down_auth}
                                             : i_hf - {1'b0, i_cfg.fmin};
        end
    end

    assign w_sq_rnd = r1_sq + P_W'(HALF_Q16);
    assign w_q_rnd  = r2_p + P_W'(HALF_Q16);
    assign w_w      = {1'b0, ONE_Q16} - {1'b0, i_cfg.expo}
                    + {1'b0, w_q_rnd[FRAC_W+QV_W-1:FRAC_W]};
    assign w_s_rnd  = r4_p + P_W'(HALF_Q16);
    assign w_d_rnd  = {1'b0, r6_p} + (PA_W+1)'(HALF_Q16);
    assign w_delta  = w_d_rnd[PA_W:FRAC_W];

    always_comb begin
        if (r6_pos) begin
            w_force = F_W'(r6_hf) + F_W'(w_delta);
        end else if (F_W'(w_delta) >= F_W'(r6_hf)) begin
            w_force = '0;
        end else begin
            w_force = F_W'(r6_hf) - F_W'(w_delta);
        end
        if (w_force < F_W'(i_cfg.fmin)) begin
            w_clamp = F_W'(i_cfg.fmin);
        end else if (w_force > F_W'(i_cfg.fmax)) begin
            w_clamp = F_W'(i_cfg.fmax);
        end else begin
            w_clamp = w_force;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 7; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int k = 2; k <= 7; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
        if (i_en) begin
            r1_r    <= i_r;
            r1_pos  <= i_pos;
            r1_hf   <= i_hf;
            r1_auth <= w_auth;
            r1_sq   <= i_r * i_r;

            r2_r    <= r1_r;
            r2_pos  <= r1_pos;
            r2_hf   <= r1_hf;
            r2_auth <= r1_auth;
            r2_p    <= i_cfg.expo * w_sq_rnd[FRAC_W+QV_W-1:FRAC_W];

            r3_r    <= r2_r;
            r3_pos  <= r2_pos;
            r3_hf   <= r2_hf;
            r3_auth <= r2_auth;
            r3_w    <= w_w[QV_W-1:0];

            r4_pos  <= r3_pos;
            r4_hf   <= r3_hf;
            r4_auth <= r3_auth;
            r4_p    <= r3_r * r3_w;

            r5_pos  <= r4_pos;
            r5_hf   <= r4_hf;
            r5_auth <= r4_auth;
            r5_s    <= w_s_rnd[FRAC_W+QV_W-1:FRAC_W];

            r6_pos  <= r5_pos;
            r6_hf   <= r5_hf;
            r6_p    <= r5_s * r5_auth;

            r7_force <= (w_clamp > F_W'(OUT_MAX)) ? OUT_MAX : w_clamp[FORCE_W-1:0];
        end
    end

    assign o_valid = r_v[7];
    assign o_force = r7_force;

endmodule

// ===== design/throttle_to_thrust_curve_unit.sv =====
// ----------------------------------------------------------------------------
// throttle_to_thrust_curve_unit
// maps stick throttle and vehicle mass to a thrust request in millinewtons
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_throttle, i_mass_grams
// result    out        o_valid / i_stall  o_force_res
// config    in         apb write / read   paddr, pwdata, prdata
//
// one request per cycle unless a stalled result holds the pipeline
// path runs through hover, the two bit-per-stage dividers (18 stages each) and curve
// a stalled result freezes the whole pipeline, nothing lost or repeated
// synchronous active-low reset clears valid bits and sets config registers to defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module throttle_to_thrust_curve_unit
    import ttc_pkg::*;
#(
    parameter int unsigned HOVER_ACCEL = HOVER_ACCEL_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [THR_W-1:0]   i_throttle,
    input  logic [MASS_W-1:0]  i_mass_grams,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FORCE_W-1:0] o_force_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        REG_MIN_FORCE,
        REG_MAX_FORCE,
        REG_HOVER_THR,
        REG_EXPO,
        REG_DEADBAND,
        REG_HOVER_FORCE,
        REG_DOWN_AUTH,
        REG_UP_AUTH
    } t_reg_idx;

    logic [FORCE_W-1:0] r_min_force, r_max_force, r_hover_force;
    logic [FORCE_W-1:0] r_down_auth, r_up_auth;
    logic [THR_W-1:0]   r_hover_thr, r_deadband;
    logic [QV_W-1:0]    r_expo;

    t_reg_idx           w_idx;
    t_cfg               w_cfg;
    logic [FMAX_W-1:0]  w_min_gap;
    logic               w_en;

    logic               w_hov_valid;
    logic [THR_W-1:0]   w_hov_thr;
    logic [FMAX_W-1:0]  w_hov_hf;
    logic               w_pos;
    logic [QV_W-1:0]    w_diff1, w_den1;

    logic               w_c_valid;
    logic [QV_W-1:0]    w_c;
    logic [SIDE_W-1:0]  w_c_side;
    logic [QV_W-1:0]    w_db, w_diff2, w_den2;

    logic               w_r_valid;
    logic [QV_W-1:0]    w_r;
    logic [SIDE_W-1:0]  w_r_side;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_force   <= '0;
            r_max_force   <= 20'd40000;
            r_hover_thr   <= 16'd32768;
            r_expo        <= '0;
            r_deadband    <= '0;
            r_hover_force <= '0;
            r_down_auth   <= '0;
            r_up_auth     <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_MIN_FORCE:   r_min_force   <= pwdata[FORCE_W-1:0];
                REG_MAX_FORCE:   r_max_force   <= pwdata[FORCE_W-1:0];
                REG_HOVER_THR:   r_hover_thr   <= pwdata[THR_W-1:0];
                REG_EXPO:        r_expo        <= pwdata[QV_W-1:0];
                REG_DEADBAND:    r_deadband    <= pwdata[THR_W-1:0];
                REG_HOVER_FORCE: r_hover_force <= pwdata[FORCE_W-1:0];
                REG_DOWN_AUTH:   r_down_auth   <= pwdata[FORCE_W-1:0];
                REG_UP_AUTH:     r_up_auth     <= pwdata[FORCE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MIN_FORCE:   prdata = 32'(r_min_force);
            REG_MAX_FORCE:   prdata = 32'(r_max_force);
            REG_HOVER_THR:   prdata = 32'(r_hover_thr);
            REG_EXPO:        prdata = 32'(r_expo);
            REG_DEADBAND:    prdata = 32'(r_deadband);
            REG_HOVER_FORCE: prdata = 32'(r_hover_force);
            REG_DOWN_AUTH:   prdata = 32'(r_down_auth);
            REG_UP_AUTH:     prdata = 32'(r_up_auth);
            default:         prdata = '0;
        endcase
    end

    // effective limits and clamped curve settings
    assign w_min_gap = {1'b0, r_min_force} + MAX_GAP;

    always_comb begin
        w_cfg.fmin      = r_min_force;
        w_cfg.fmax      = ({1'b0, r_max_force} < w_min_gap) ? w_min_gap
                                                            : {1'b0, r_max_force};
        if (r_hover_thr < HT_LOW) begin
            w_cfg.hov_thr = HT_LOW;
        end else if (r_hover_thr > HT_HIGH) begin
            w_cfg.hov_thr = HT_HIGH;
        end else begin
            w_cfg.hov_thr = r_hover_thr;
        end
        w_cfg.expo      = (r_expo > ONE_Q16) ? ONE_Q16 : r_expo;
        w_cfg.dband     = ({1'b0, r_deadband} > HALF_Q16) ? HALF_Q16[THR_W-1:0]
                                                          : r_deadband;
        w_cfg.hov_force = r_hover_force;
        w_cfg.down_auth = r_down_auth;
        w_cfg.up_auth   = r_up_auth;
    end

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    ttc_hover #(
        .HOVER_ACCEL(HOVER_ACCEL)
    ) u_hover (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_throttle (i_throttle),
        .i_mass     (i_mass_grams),
        .i_cfg      (w_cfg),
        .o_valid    (w_hov_valid),
        .o_throttle (w_hov_thr),
        .o_hf       (w_hov_hf)
    );

    // centre on hover, scale by lower or upper span
    assign w_pos   = w_hov_thr >= w_cfg.hov_thr;
    assign w_diff1 = w_pos ? QV_W'(w_hov_thr - w_cfg.hov_thr)
                           : QV_W'(w_cfg.hov_thr - w_hov_thr);
    assign w_den1  = w_pos ? ONE_Q16 - {1'b0, w_cfg.hov_thr} : {1'b0, w_cfg.hov_thr};

    ttc_div #(
        .SIDE_BITS(SIDE_W)
    ) u_div_centre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_hov_valid),
        .i_diff  (w_diff1),
        .i_den   (w_den1),
        .i_side  ({w_pos, w_hov_hf}),
        .o_valid (w_c_valid),
        .o_quot  (w_c),
        .o_side  (w_c_side)
    );

    // deadband with rescale, zero numerator inside the band
    assign w_db    = {1'b0, w_cfg.dband};
    assign w_diff2 = (w_c > w_db) ? w_c - w_db : '0;
    assign w_den2  = ONE_Q16 - w_db;

    ttc_div #(
        .SIDE_BITS(SIDE_W)
    ) u_div_dband (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c_valid),
        .i_diff  (w_diff2),
        .i_den   (w_den2),
        .i_side  (w_c_side),
        .o_valid (w_r_valid),
        .o_quot  (w_r),
        .o_side  (w_r_side)
    );

    ttc_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_r_valid),
        .i_r     (w_r),
        .i_pos   (w_r_side[SIDE_W-1]),
        .i_hf    (w_r_side[FMAX_W-1:0]),
        .i_cfg   (w_cfg),
        .o_valid (o_valid),
        .o_force (o_force_res)
    );

    `ASSERT_IMPLIES(a_centre_range, i_clk, i_rst_n, w_c_valid, w_c <= ONE_Q16, "centred value above one")
    `ASSERT_IMPLIES(a_dband_range, i_clk, i_rst_n, w_r_valid, w_r <= ONE_Q16, "rescaled value above one")
    `ASSERT_ALWAYS(a_stall_link, i_clk, i_rst_n, !o_stall || o_valid, "input held without a pending result")

endmodule

// ===== dv/ttc_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_tb_pkg
// register map of the thrust curve unit as seen by the testbench
// ----------------------------------------------------------------------------
package ttc_tb_pkg;

    typedef enum logic [2:0] {
        REG_MIN_FORCE = 3'd0,
        REG_MAX_FORCE = 3'd1,
        REG_HOVER_THR = 3'd2,
        REG_EXPO      = 3'd3,
        REG_DEADBAND  = 3'd4,
        REG_HOVER_F   = 3'd5,
        REG_DOWN_AUTH = 3'd6,
        REG_UP_AUTH   = 3'd7
    } t_reg;

endpackage

// ===== dv/throttle_to_thrust_curve_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_to_thrust_curve_checker
// watches the request, result and register ports, predicts the thrust of
// every accepted request from its own copy of the registers and compares it
// in order with each accepted result
// ----------------------------------------------------------------------------
module throttle_to_thrust_curve_checker
    import ttc_pkg::*;
    import ttc_tb_pkg::*;
#(
    parameter int unsigned ACCEL = HOVER_ACCEL_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [THR_W-1:0]   i_throttle,
    input  logic [MASS_W-1:0]  i_mass_grams,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [FORCE_W-1:0] i_force_res,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_errors,
    output int                 o_pending
);

    longint unsigned min_f, max_f, hov_thr, expo_w, dband, hov_f, down_a, up_a;
    logic [FORCE_W-1:0] thrust_q[$];

    function automatic longint unsigned clampu(longint unsigned v, longint unsigned lo,
                                               longint unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic logic [FORCE_W-1:0] thrust_of(longint unsigned t, longint unsigned m);
        longint unsigned fmax, h, e, db, hf, c, r, r2, q, w, s, up, dn, dl, f;
        bit pos;
        fmax = max_f;
        h = clampu(hov_thr, 3277, 62259);
        e = clampu(expo_w, 0, 65536);
        db = clampu(dband, 0, 32768);
        if (fmax < min_f + 1000) fmax = min_f + 1000;
        hf = (hov_f != 0) ? hov_f : rdiv(m * ACCEL, 1000);
        hf = clampu(hf, min_f, fmax);
        pos = (t >= h);
        c = pos ? rdiv((t - h) << 16, 65536 - h) : rdiv((h - t) << 16, h);
        if (c > 65536) c = 65536;
        r = (c <= db) ? 0 : rdiv((c - db) << 16, 65536 - db);
        if (r > 65536) r = 65536;
        r2 = (r * r + 32768) >> 16;
        q = (e * r2 + 32768) >> 16;
        w = (65536 - e) + q;
        s = (r * w + 32768) >> 16;
        up = (up_a != 0) ? up_a : fmax - hf;
        dn = (down_a != 0) ? down_a : hf - min_f;
        if (pos) begin
            dl = (s * up + 32768) >> 16;
            f = hf + dl;
        end else begin
            dl = (s * dn + 32768) >> 16;
            f = (dl >= hf) ? 0 : hf - dl;
        end
        f = clampu(f, min_f, fmax);
        if (f > 1048575) f = 1048575;
        return f[FORCE_W-1:0];
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [FORCE_W-1:0] want;
        if (!i_rst_n) begin
            min_f = 0; max_f = 40000; hov_thr = 32768; expo_w = 0;
            dband = 0; hov_f = 0; down_a = 0; up_a = 0;
            thrust_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[4:2]))
                    REG_MIN_FORCE: min_f   = i_pwdata[19:0];
                    REG_MAX_FORCE: max_f   = i_pwdata[19:0];
                    REG_HOVER_THR: hov_thr = i_pwdata[15:0];
                    REG_EXPO:      expo_w  = i_pwdata[16:0];
                    REG_DEADBAND:  dband   = i_pwdata[15:0];
                    REG_HOVER_F:   hov_f   = i_pwdata[19:0];
                    REG_DOWN_AUTH: down_a  = i_pwdata[19:0];
                    REG_UP_AUTH:   up_a    = i_pwdata[19:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (thrust_q.size() == 0) begin
                    report($sformatf("unexpected result force %0d", i_force_res));
                end else begin
                    want = thrust_q.pop_front();
                    if (i_force_res !== want)
                        report($sformatf("force %0d, expected %0d", i_force_res, want));
                end
            end
            if (i_valid && !i_in_stall)
                thrust_q.push_back(thrust_of(i_throttle, i_mass_grams));
        end
        o_pending = thrust_q.size();
    end

endmodule

// ===== dv/throttle_to_thrust_curve_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_to_thrust_curve_unit_tb
// drives directed and random throttle and mass requests through several
// register settings and idle patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module throttle_to_thrust_curve_unit_tb;
    import ttc_pkg::*;
    import ttc_tb_pkg::*;

    localparam int LIMIT = 2000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [THR_W-1:0]   i_throttle = '0;
    logic [MASS_W-1:0]  i_mass_grams = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [FORCE_W-1:0] o_force_res;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors, pending, cycles = 0;
    int                 send_idle = 0, recv_stall = 0;

    always #5 i_clk = ~i_clk;

    throttle_to_thrust_curve_unit dut (.*);

    throttle_to_thrust_curve_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_throttle, .i_mass_grams,
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_force_res(o_force_res),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_stall <= ($urandom_range(99) < recv_stall);
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(t_reg idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send(logic [15:0] thr, logic [15:0] mass);
        i_valid <= 1'b1; i_throttle <= thr; i_mass_grams <= mass;
        do @(posedge i_clk); while (o_stall);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (i_valid) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] mn, logic [31:0] mx, logic [31:0] ht, logic [31:0] ex,
                           logic [31:0] db, logic [31:0] hf, logic [31:0] da,
                           logic [31:0] ua);
        reg_write(REG_MIN_FORCE, mn);
        reg_write(REG_MAX_FORCE, mx);
        reg_write(REG_HOVER_THR, ht);
        reg_write(REG_EXPO, ex);
        reg_write(REG_DEADBAND, db);
        reg_write(REG_HOVER_F, hf);
        reg_write(REG_DOWN_AUTH, da);
        reg_write(REG_UP_AUTH, ua);
    endtask

    function automatic logic [15:0] pick_thr(logic [15:0] hov);
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return hov + 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_mass();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(5000));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] hov;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: extremes, hover point, neighbors of hover
        send(16'd0, 16'd0);
        send(16'hFFFF, 16'hFFFF);
        send(16'd32768, 16'd1000);
        send(16'd32767, 16'd1000);
        send(16'd32769, 16'd1000);
        send(16'd0, 16'hFFFF);
        send(16'hFFFF, 16'd0);
        drain();

        // max below min, raw registers out of range, saturation at the top
        set_all(32'hFFFFF, 32'd0, 32'd0, 32'h1FFFF, 32'hFFFF, 32'd0, 32'hFFFFF, 32'hFFFFF);
        send(16'd0, 16'hFFFF);
        send(16'hFFFF, 16'hFFFF);
        send(16'd3277, 16'd0);
        send(16'd3276, 16'd500);
        drain();
        set_all(32'd0, 32'hFFFFF, 32'hFFFF, 32'd65536, 32'd32768, 32'hFFFFF, 32'd0, 32'd0);
        send(16'd0, 16'd0);
        send(16'hFFFF, 16'd0);
        send(16'd62259, 16'd0);
        send(16'd20000, 16'd0);
        drain();
        // force pushed below zero by a large down span
        set_all(32'd0, 32'd80000, 32'd30000, 32'd40000, 32'd1000, 32'd5000, 32'hFFFFF,
                32'd100);
        send(16'd0, 16'd0);
        send(16'd29000, 16'd0);
        send(16'd31000, 16'd0);
        send(16'hFFFF, 16'd0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 57; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 57; end
                default: begin send_idle = 12; recv_stall = 12; end
            endcase
            hov = 16'($urandom_range(70000) < 5000 ? $urandom : $urandom_range(3277, 62259));
            set_all($urandom_range(3) == 0 ? $urandom : $urandom_range(3000),
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(200000),
                    hov,
                    $urandom_range(5) == 0 ? $urandom : $urandom_range(65536),
                    $urandom_range(5) == 0 ? $urandom : $urandom_range(12000),
                    $urandom_range(1) == 0 ? 32'd0 : $urandom_range(100000),
                    $urandom_range(2) == 0 ? 32'd0 : $urandom,
                    $urandom_range(2) == 0 ? 32'd0 : $urandom);
            repeat (100) send(pick_thr(hov), pick_mass());
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
